@@ rtl/core/fcgi_nvd_pkg.sv @@
package fcgi_nvd_pkg;

    localparam int unsigned LenW       = 31;
    localparam int unsigned CountW     = 32;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned LongBit    = 7;
    localparam logic [6:0]  Low7Mask   = 7'h7f;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned TdataW     = 72;
    localparam int unsigned TuserW     = 2;

    // one-hot parser phases
    typedef enum logic [8:0] {
        PH_NL0  = 9'b000000001,
        PH_NL1  = 9'b000000010,
        PH_NL2  = 9'b000000100,
        PH_NL3  = 9'b000001000,
        PH_VL0  = 9'b000010000,
        PH_VL1  = 9'b000100000,
        PH_VL2  = 9'b001000000,
        PH_VL3  = 9'b010000000,
        PH_DATA = 9'b100000000
    } t_phase;

    // one emitted payload byte with its tags
    typedef struct packed {
        logic [LenW-1:0]  value_length;
        logic [LenW-1:0]  name_length;
        logic             pair_last;
        logic             pair_first;
        logic             in_value;
        logic [ByteW-1:0] payload_byte;
    } t_item;

    // queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ rtl/core/fcgi_nvd_front.sv @@
module fcgi_nvd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [fcgi_nvd_pkg::ByteW-1:0] i_byte,
    input  fcgi_nvd_pkg::t_q_status     i_q_status,
    output logic                        o_push,
    output fcgi_nvd_pkg::t_item         o_item
);

    fcgi_nvd_pkg::t_phase r_phase, n_phase;
    logic [fcgi_nvd_pkg::LenW-1:0]   r_name_len, n_name_len;
    logic [fcgi_nvd_pkg::LenW-1:0]   r_value_len, n_value_len;
    logic [fcgi_nvd_pkg::CountW-1:0] r_bytes_left, n_bytes_left;
    logic r_skip, n_skip;
    logic r_first, n_first;

    logic                          take;
    logic                          is_long;
    logic [fcgi_nvd_pkg::LenW-1:0] short_len;
    logic [fcgi_nvd_pkg::LenW-1:0] long_start;
    logic [fcgi_nvd_pkg::LenW-1:0] name_shift;
    logic [fcgi_nvd_pkg::LenW-1:0] value_shift;
    logic [fcgi_nvd_pkg::LenW-1:0] begin_value;
    logic                          do_begin;
    logic                          last_byte;
    logic                          emit;

    assign o_ready    = !i_q_status.full;
    assign take       = i_valid && o_ready;
    assign is_long    = i_byte[fcgi_nvd_pkg::LongBit];
    assign short_len  = {{(fcgi_nvd_pkg::LenW-fcgi_nvd_pkg::ByteW){1'b0}}, i_byte};
    assign long_start = {{(fcgi_nvd_pkg::LenW-7){1'b0}}, i_byte[6:0] & fcgi_nvd_pkg::Low7Mask};
    assign name_shift = {r_name_len[fcgi_nvd_pkg::LenW-fcgi_nvd_pkg::ByteW-1:0], i_byte};
    assign value_shift = {r_value_len[fcgi_nvd_pkg::LenW-fcgi_nvd_pkg::ByteW-1:0], i_byte};

    assign last_byte = (r_bytes_left <= fcgi_nvd_pkg::CountW'(1));
    assign emit      = (r_phase == fcgi_nvd_pkg::PH_DATA) && !r_skip;

    always_comb begin
        n_phase      = r_phase;
        n_name_len   = r_name_len;
        n_value_len  = r_value_len;
        n_bytes_left = r_bytes_left;
        n_skip       = r_skip;
        n_first      = r_first;
        do_begin     = 1'b0;
        begin_value  = short_len;
        if (take) begin
            case (r_phase)
                fcgi_nvd_pkg::PH_NL0: begin
                    if (is_long) begin
                        n_name_len = long_start;
                        n_phase    = fcgi_nvd_pkg::PH_NL1;
                    end else begin
                        n_name_len = short_len;
                        n_phase    = fcgi_nvd_pkg::PH_VL0;
                    end
                end
                fcgi_nvd_pkg::PH_NL1: begin
                    n_name_len = name_shift;
                    n_phase    = fcgi_nvd_pkg::PH_NL2;
                end
                fcgi_nvd_pkg::PH_NL2: begin
                    n_name_len = name_shift;
                    n_phase    = fcgi_nvd_pkg::PH_NL3;
                end
                fcgi_nvd_pkg::PH_NL3: begin
                    n_name_len = name_shift;
                    n_phase    = fcgi_nvd_pkg::PH_VL0;
                end
                fcgi_nvd_pkg::PH_VL0: begin
                    if (is_long) begin
                        n_value_len = long_start;
                        n_phase     = fcgi_nvd_pkg::PH_VL1;
                    end else begin
                        begin_value = short_len;
                        do_begin    = 1'b1;
                    end
                end
                fcgi_nvd_pkg::PH_VL1: begin
                    n_value_len = value_shift;
                    n_phase     = fcgi_nvd_pkg::PH_VL2;
                end
                fcgi_nvd_pkg::PH_VL2: begin
                    n_value_len = value_shift;
                    n_phase     = fcgi_nvd_pkg::PH_VL3;
                end
                fcgi_nvd_pkg::PH_VL3: begin
                    begin_value = value_shift;
                    do_begin    = 1'b1;
                end
                fcgi_nvd_pkg::PH_DATA: begin
                    if (!r_skip) begin
                        n_first = 1'b0;
                    end
                    if (last_byte) begin
                        n_bytes_left = '0;
                        n_skip       = 1'b0;
                        n_first      = 1'b1;
                        n_phase      = fcgi_nvd_pkg::PH_NL0;
                    end else begin
                        n_bytes_left = r_bytes_left - fcgi_nvd_pkg::CountW'(1);
                    end
                end
                default: begin
                    n_phase = fcgi_nvd_pkg::PH_NL0;
                end
            endcase
            if (do_begin) begin
                // payload length = name + value, zero means next byte opens a new pair
                n_value_len  = begin_value;
                n_skip       = (begin_value == '0);
                n_first      = 1'b1;
                n_bytes_left = {1'b0, r_name_len} + {1'b0, begin_value};
                n_phase      = ((r_name_len == '0) && (begin_value == '0)) ?
                               fcgi_nvd_pkg::PH_NL0 : fcgi_nvd_pkg::PH_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= fcgi_nvd_pkg::PH_NL0;
            r_name_len   <= '0;
            r_value_len  <= '0;
            r_bytes_left <= '0;
            r_skip       <= 1'b0;
            r_first      <= 1'b1;
        end else begin
            r_phase      <= n_phase;
            r_name_len   <= n_name_len;
            r_value_len  <= n_value_len;
            r_bytes_left <= n_bytes_left;
            r_skip       <= n_skip;
            r_first      <= n_first;
        end
    end

    assign o_push = take && emit;

    always_comb begin
        o_item.payload_byte = i_byte;
        o_item.in_value     = (r_bytes_left <= {1'b0, r_value_len});
        o_item.pair_first   = r_first;
        o_item.pair_last    = last_byte;
        o_item.name_length  = r_name_len;
        o_item.value_length = r_value_len;
    end

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == fcgi_nvd_pkg::PH_DATA) |-> (r_bytes_left != '0))
        else $error("payload phase with no bytes left");

    a_push_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_phase == fcgi_nvd_pkg::PH_DATA) && (r_value_len != '0))
        else $error("push outside a kept pair payload");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (r_phase == fcgi_nvd_pkg::PH_DATA) && last_byte)
        |=> (r_phase == fcgi_nvd_pkg::PH_NL0) && r_first && !r_skip)
        else $error("pair end did not restart length decode");

endmodule

@@ rtl/core/fcgi_nvd_queue.sv @@
module fcgi_nvd_queue #(
    parameter int unsigned DEPTH = fcgi_nvd_pkg::QueueDepth
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  fcgi_nvd_pkg::t_item     i_item,
    input  logic                    i_pop,
    output fcgi_nvd_pkg::t_item     o_item,
    output fcgi_nvd_pkg::t_q_status o_status
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    fcgi_nvd_pkg::t_item r_slots [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_status.full  = (r_count == FullCnt);
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_item  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PtrW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CntW'(1);
                2'b01:   r_count <= r_count - CntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCnt)
        else $error("queue count overflow");

endmodule

@@ rtl/core/fcgi_nvd_back.sv @@
module fcgi_nvd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fcgi_nvd_pkg::t_q_status i_q_status,
    input  fcgi_nvd_pkg::t_item     i_item,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output fcgi_nvd_pkg::t_item     o_item
);

    logic                r_valid, n_valid;
    fcgi_nvd_pkg::t_item r_item;

    // refill output register whenever it is empty or being drained
    assign o_pop   = !i_q_status.empty && (!r_valid || i_ready);
    assign n_valid = o_pop || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> r_valid && $stable(r_item))
        else $error("output register changed while stalled");

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped item not held");

    a_no_idle_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_valid && !i_q_status.empty) |-> o_pop)
        else $error("output idle while queue holds items");

endmodule

@@ rtl/core/fastcgi_name_value_deframer.sv @@
// FastCGI name-value deframer. Takes the parameter stream one byte per request on the
// s_axis side, decodes each pair's name and value lengths (one byte when bit 7 is clear,
// else four bytes big-endian with bit 7 masked) and sends every name and value byte out
// on m_axis: tdata carries the byte and both lengths, tuser says name or value and marks
// the pair's first byte, tlast marks its last byte. Length bytes and all bytes of a pair
// with a zero value length give no output. Rate: one input byte every cycle, at most one
// output request every cycle; each byte passes through the queue, then the output register.
// A queue of QUEUE_DEPTH entries sits between the parser and the output register, so
// s_axis_tready drops only when that queue is full because the output side has been stalled.
module fastcgi_name_value_deframer #(
    parameter int unsigned QUEUE_DEPTH = fcgi_nvd_pkg::QueueDepth
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [fcgi_nvd_pkg::ByteW-1:0]    s_axis_tdata,  // [7:0] in_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fcgi_nvd_pkg::TdataW-1:0]   m_axis_tdata,  // [7:0] payload_byte,
                                                             // [38:8] name_length,
                                                             // [69:39] value_length, rest 0
    output logic [fcgi_nvd_pkg::TuserW-1:0]   m_axis_tuser,  // [0] in_value, [1] pair_first
    output logic                              m_axis_tlast   // pair_last
);

    // front -> queue
    logic                    push;
    fcgi_nvd_pkg::t_item     front_item;
    // queue -> back
    logic                    pop;
    fcgi_nvd_pkg::t_item     q_item;
    fcgi_nvd_pkg::t_q_status q_status;
    // output register
    fcgi_nvd_pkg::t_item     out_item;

    // length decode and byte classification
    fcgi_nvd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (front_item)
    );

    // decouples parser from output stalls
    fcgi_nvd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (q_item),
        .o_status (q_status)
    );

    // registered master side
    fcgi_nvd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_item     (q_item),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_item     (out_item)
    );

    assign m_axis_tdata = {2'b00, out_item.value_length, out_item.name_length,
                           out_item.payload_byte};
    assign m_axis_tuser = {out_item.pair_first, out_item.in_value};
    assign m_axis_tlast = out_item.pair_last;

endmodule
